[rtl/segtr_pkg.sv]
// Shared types and constants for the range-sum tree block.
`timescale 1ns / 1ps
`default_nettype none

package segtr_pkg;

  localparam int MAX_POSITIONS_DEF = 1024;

  localparam int SIZE_W  = 11;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 64;
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  // register index is the word address, paddr[2]
  localparam logic REG_SIZE_IDX = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET   = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QA,
    ST_QB,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

[rtl/segment_tree_range_sum_top.sv]
// Top level of the range-sum tree with point updates.
`timescale 1ns / 1ps
`default_nettype none

// Bottom-up sum tree of 2*MAX_POSITIONS 64-bit nodes held in one RAM with a
// registered read. For a set or add the leaf is read on the accepting cycle,
// then one node is written per cycle while its parent is read, the new value
// carried up as a delta. A query examines two tree nodes per level, one RAM
// read each. Only queries return a transaction on the output; the result
// register lets the next item be accepted while it waits. After reset and
// after every write of the size register the whole RAM is cleared, during
// which no item is accepted.
module segment_tree_range_sum_top
  import segtr_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [KIND_W-1:0]  kind_i,
  input  wire logic [POS_W-1:0]   position_i,
  input  wire logic [POS_W-1:0]   range_right_i,
  input  wire logic signed [VAL_W-1:0] value_i,

  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [SUM_W-1:0] range_sum_o,

  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic      [APB_DW-1:0]  prdata,
  output logic                    pready
);

  localparam int DEPTH = 2 * MAX_POSITIONS;
  localparam int NW    = $clog2(DEPTH);
  localparam int AW    = NW + 1;
  localparam int NBITS = $clog2(MAX_POSITIONS + 1);
  localparam int CMPW  = (NBITS > SIZE_W) ? NBITS : SIZE_W;

  state_e            state_q, state_d;
  logic [NW-1:0]     clr_q, clr_d;
  logic [NW-1:0]     node_q, node_d;
  logic              first_q, first_d;
  logic              set_q, set_d;
  logic [SUM_W-1:0]  val_q, val_d;
  logic [SUM_W-1:0]  delta_q, delta_d;
  logic [AW-1:0]     a_q, a_d;
  logic [AW-1:0]     b_q, b_d;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic              pend_q, pend_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  sum_q, sum_d;

  logic              ram_we;
  logic [NW-1:0]     ram_waddr;
  logic [SUM_W-1:0]  ram_wdata;
  logic [NW-1:0]     ram_raddr;
  logic [SUM_W-1:0]  ram_rdata;

  logic              in_fire;
  logic              cfg_wr;
  logic [CMPW-1:0]   n_use;
  logic [CMPW-1:0]   pos_ext;
  logic [CMPW-1:0]   right_ext;
  logic [CMPW-1:0]   right_clip;
  logic              pos_in;
  logic              q_ok;
  logic [SUM_W-1:0]  val_ext;
  logic [AW-1:0]     b_dec;

  segtr_ram #(
    .WIDTH(SUM_W),
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign range_sum_o = sum_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SIZE_IDX) ? APB_DW'(size_q) : '0;

  // positions in use: register capped at the tree capacity
  assign n_use = (CMPW'(size_q) > CMPW'(MAX_POSITIONS)) ? CMPW'(MAX_POSITIONS)
                                                         : CMPW'(size_q);
  assign pos_ext    = CMPW'(position_i);
  assign right_ext  = CMPW'(range_right_i);
  assign pos_in     = (pos_ext < n_use);
  assign q_ok       = pos_in && (pos_ext <= right_ext);
  assign right_clip = (right_ext > (n_use - CMPW'(1))) ? (n_use - CMPW'(1)) : right_ext;
  assign val_ext    = SUM_W'(value_i);
  assign b_dec      = b_q - AW'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    first_d     = first_q;
    set_d       = set_q;
    val_d       = val_q;
    delta_d     = delta_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    pend_d      = 1'b0;
    size_d      = size_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !out_ready_i;

    ram_we    = 1'b0;
    ram_waddr = node_q;
    ram_wdata = '0;
    ram_raddr = node_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + NW'(1);
        if (clr_q == NW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // leaf is read speculatively for an update
        ram_raddr = NW'(position_i) + NW'(MAX_POSITIONS);
        if (in_fire) begin
          case (kind_e'(kind_i))
            KIND_SET, KIND_ADD: begin
              if (pos_in) begin
                node_d  = NW'(position_i) + NW'(MAX_POSITIONS);
                first_d = 1'b1;
                set_d   = (kind_e'(kind_i) == KIND_SET);
                val_d   = val_ext;
                state_d = ST_UPD;
              end
            end
            KIND_QUERY: begin
              acc_d   = '0;
              state_d = ST_QA;
              if (q_ok) begin
                a_d = AW'(position_i) + AW'(MAX_POSITIONS);
                b_d = AW'(right_clip) + AW'(MAX_POSITIONS) + AW'(1);
              end else begin
                a_d = '0;
                b_d = '0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_UPD: begin
        // write this node, read its parent; ancestors move by the leaf delta
        ram_we = 1'b1;
        if (first_q) begin
          ram_wdata = set_q ? val_q : (ram_rdata + val_q);
          delta_d   = set_q ? (val_q - ram_rdata) : val_q;
        end else begin
          ram_wdata = ram_rdata + delta_q;
        end
        first_d   = 1'b0;
        ram_raddr = node_q >> 1;
        node_d    = node_q >> 1;
        if (node_q == NW'(1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_QA: begin
        acc_d = acc_q + (pend_q ? ram_rdata : '0);
        if (a_q < b_q) begin
          ram_raddr = a_q[NW-1:0];
          if (a_q[0]) begin
            pend_d = 1'b1;
            a_d    = a_q + AW'(1);
          end
          state_d = ST_QB;
        end else begin
          state_d = ST_OUT;
        end
      end

      ST_QB: begin
        acc_d     = acc_q + (pend_q ? ram_rdata : '0);
        ram_raddr = b_dec[NW-1:0];
        pend_d    = b_q[0];
        a_d       = a_q >> 1;
        b_d       = b_q >> 1;
        state_d   = ST_QA;
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          sum_d       = acc_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // a size write rebuilds an empty tree
    if (cfg_wr && (paddr[2] == REG_SIZE_IDX)) begin
      size_d  = pwdata[SIZE_W-1:0];
      clr_d   = '0;
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      first_q     <= 1'b0;
      pend_q      <= 1'b0;
      size_q      <= SIZE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    set_q   <= set_d;
    val_q   <= val_d;
    delta_q <= delta_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    sum_q   <= sum_d;
  end

endmodule

`default_nettype wire

[rtl/segtr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module segtr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[bench/tb_segment_tree_range_sum_top.sv]
// Self-checking testbench for the range-sum tree block: point updates and range queries.
`timescale 1ns / 1ps

module tb_segment_tree_range_sum_top;
  import segtr_pkg::*;

  localparam int MAX_POS      = MAX_POSITIONS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYC   = 40;
  localparam int REPORT_LIMIT = 10;

  localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_SIZE   = PADDR_W'(4 * REG_SIZE_IDX);
  // word address with no register behind it
  localparam logic [PADDR_W-1:0] ADDR_SPARE  = 3'd4;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i;
  logic [POS_W-1:0]    position_i;
  logic [POS_W-1:0]    range_right_i;
  logic [VAL_W-1:0]    value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SUM_W-1:0]    range_sum_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  segment_tree_range_sum_top #(
    .MAX_POSITIONS(MAX_POS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .range_right_i (range_right_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .range_sum_o   (range_sum_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow of the array contents and the size register
  logic [SUM_W-1:0]  leaf_vals [MAX_POS];
  logic [SIZE_W-1:0] size_reg;
  logic [SUM_W-1:0]  sums_due [$];
  logic [SUM_W-1:0]  due_sum;

  int failures;
  int cycle_count;
  int idle_pct;
  int stall_pct;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("segment_tree_range_sum_top regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sums_due.size() == 0) begin
        note_failure($sformatf("range_sum %h with no query pending", range_sum_o));
      end else begin
        due_sum = sums_due.pop_front();
        if (range_sum_o !== due_sum) begin
          note_failure($sformatf("range_sum expected %h got %h", due_sum, range_sum_o));
        end
      end
    end
  end

  function automatic int positions_used();
    int n;
    n = int'(size_reg);
    if (n > MAX_POS) n = MAX_POS;
    return n;
  endfunction

  function automatic logic [SUM_W-1:0] range_sum_of(input int lo, input int hi);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = lo; i <= hi; i++) acc += leaf_vals[i];
    return acc;
  endfunction

  function automatic void clear_store();
    foreach (leaf_vals[i]) leaf_vals[i] = '0;
  endfunction

  task automatic apply_item(input logic [KIND_W-1:0] kind, input int pos, input int right,
                            input logic [VAL_W-1:0] val);
    int n;
    int hi;
    logic [SUM_W-1:0] ext;
    n   = positions_used();
    ext = {{(SUM_W - VAL_W){val[VAL_W-1]}}, val};
    case (kind)
      KIND_SET: begin
        if (pos < n) leaf_vals[pos] = ext;
      end
      KIND_ADD: begin
        if (pos < n) leaf_vals[pos] += ext;
      end
      KIND_QUERY: begin
        hi = right;
        if (pos < n && pos <= right) begin
          if (hi > n - 1) hi = n - 1;
          sums_due.push_back(range_sum_of(pos, hi));
        end else begin
          sums_due.push_back('0);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [KIND_W-1:0] kind, input int pos, input int right,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 50) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    kind_i        = kind;
    position_i    = POS_W'(pos);
    range_right_i = POS_W'(right);
    value_i       = val;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(kind, pos, right, val);
  endtask

  // drain results, let a trailing update finish, then wait for the block to take input
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_SIZE) begin
      size_reg = data[SIZE_W-1:0];
      clear_store();
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read_check(input logic [PADDR_W-1:0] addr, input logic [APB_DW-1:0] want);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      note_failure($sformatf("prdata at %0d expected %h got %h", addr, want, prdata));
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_size(input logic [APB_DW-1:0] data);
    wait_quiet();
    apb_write(ADDR_SIZE, data);
    apb_read_check(ADDR_SIZE, APB_DW'(data[SIZE_W-1:0]));
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly in-range updates and well-formed queries, with some noise
  task automatic send_random_item();
    int n;
    int r;
    int lo;
    int hi;
    logic [KIND_W-1:0] kind;
    n    = positions_used();
    r    = $urandom_range(99);
    lo   = $urandom_range(MAX_POS - 1);
    hi   = $urandom_range(MAX_POS - 1);
    kind = KIND_UNUSED;
    if (n > 0 && r < 35) begin
      kind = KIND_SET;
      lo   = $urandom_range(n - 1);
    end else if (n > 0 && r < 60) begin
      kind = KIND_ADD;
      lo   = $urandom_range(n - 1);
    end else if (n > 0 && r < 85) begin
      kind = KIND_QUERY;
      lo   = $urandom_range(n - 1);
      if ($urandom_range(9) == 0) hi = $urandom_range(MAX_POS - 1, lo);
      else hi = $urandom_range(n - 1, lo);
    end else if (r < 92) begin
      kind = $urandom_range(1) ? KIND_SET : KIND_ADD;
    end else if (r < 97) begin
      kind = KIND_QUERY;
    end
    send_item(kind, lo, hi, pick_value());
  endtask

  task automatic test_reset_state();
    apb_read_check(ADDR_SIZE, APB_DW'(SIZE_RESET));
    send_item(KIND_QUERY, 0, MAX_POS - 1, '0);
    send_item(KIND_SET, 0, 0, 32'h7FFF_FFFF);
    send_item(KIND_SET, MAX_POS - 1, 0, 32'h8000_0000);
    send_item(KIND_ADD, 0, MAX_POS - 1, 32'h7FFF_FFFF);
    send_item(KIND_QUERY, 0, MAX_POS - 1, 32'hFFFF_FFFF);
    send_item(KIND_QUERY, MAX_POS - 1, MAX_POS - 1, '0);
    send_item(KIND_QUERY, 5, 4, '0);
    send_item(KIND_UNUSED, 0, MAX_POS - 1, 32'd123);
    send_item(KIND_QUERY, 0, 0, '0);
  endtask

  task automatic test_size_extremes();
    // empty array
    set_size(0);
    send_item(KIND_SET, 0, 0, 32'd5);
    send_item(KIND_ADD, 0, 0, 32'd5);
    send_item(KIND_QUERY, 0, MAX_POS - 1, '0);
    // one position: right end clipped, updates past it dropped
    set_size(1);
    send_item(KIND_SET, 0, 0, 32'hFFFF_FFF9);
    send_item(KIND_SET, 1, 0, 32'd9);
    send_item(KIND_ADD, 0, 0, 32'h7FFF_FFFF);
    send_item(KIND_QUERY, 0, MAX_POS - 1, '0);
    send_item(KIND_QUERY, 1, 1, '0);
    // all ones in the size register, capped at the tree size
    set_size(32'hFFFF_FFFF);
    send_item(KIND_SET, MAX_POS - 1, 0, 32'h7FFF_FFFF);
    send_item(KIND_ADD, MAX_POS - 1, 0, 32'h7FFF_FFFF);
    send_item(KIND_QUERY, 1000, MAX_POS - 1, '0);
    // unmapped register: no clear, no size change
    wait_quiet();
    apb_write(ADDR_SPARE, 32'd5);
    apb_read_check(ADDR_SIZE, APB_DW'(size_reg));
    send_item(KIND_QUERY, 0, MAX_POS - 1, '0);
    set_size(2);
    send_item(KIND_SET, 0, 0, 32'h8000_0000);
    send_item(KIND_SET, 1, 0, 32'h8000_0000);
    send_item(KIND_QUERY, 0, 1, '0);
    send_item(KIND_QUERY, 1, 0, '0);
  endtask

  task automatic run_phase(input int size, input int idle, input int stall, input int count);
    set_size(size);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_random_item();
  endtask

  task automatic test_random();
    run_phase(8, 0, 0, 100);
    run_phase(MAX_POS, 60, 0, 80);
    run_phase(37, 0, 60, 100);
    run_phase(3, 27, 27, 60);
    run_phase(600, 27, 27, 60);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_SET;
    position_i    = '0;
    range_right_i = '0;
    value_i       = '0;
    out_ready_i   = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    failures      = 0;
    cycle_count   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    size_reg      = SIZE_RESET;
    clear_store();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_size_extremes();
    test_random();
    wait_quiet();

    if (failures == 0) begin
      $display("segment_tree_range_sum_top regression: pass");
    end else begin
      $display("segment_tree_range_sum_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/segtr_pkg.sv
rtl/segtr_ram.sv
rtl/segment_tree_range_sum_top.sv
bench/tb_segment_tree_range_sum_top.sv
